// ----- rtl/imh_pkg.sv -----
// shared constants and types for the indexed min-heap
package imh_pkg;
   localparam int CAPACITY = 256;
   localparam int KEY_BITS = 32;
   localparam int SLOT_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = SLOT_BITS + 1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_LOAD   = 2'd1,
      OP_BUILD  = 2'd2,
      OP_UPDATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_NO_ID   = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;
endpackage

// ----- rtl/imh_ram.sv -----
// generic single-write, single-read ram with registered read data
module imh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/indexed_min_heap.sv -----
// indexed min-heap top level: heap slots, position map and sift sequencer
// One word is taken at a time. The next word is accepted as soon as the sequencer
// is idle, even while the previous result waits in the output register. A clear,
// a load or a refused word goes through S_TOP, S_TOPW and S_OUT to its result. An
// update looks up the position map, then sifts down or bubbles up one level at a
// time, over at most log2 of capacity levels. The single read port of each slot
// memory sets the pace: each level down reads the two children one after another,
// then writes the swap back in S_DECIDE and S_SWAP1. Build runs the same sift for
// every internal node, from the last one down to the root, and stalls the input
// while it runs. Slot and position memories hold no reset state.
module indexed_min_heap (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // op[1:0], entry_id[9:2], key[41:10], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // top_id[7:0], top_key[39:8], entry_count[48:40],
                                   // heap_empty[49], status[51:50], zeros
);
   localparam int SB = imh_pkg::SLOT_BITS;
   localparam int CB = imh_pkg::CNT_BITS;
   localparam int KB = imh_pkg::KEY_BITS;

   typedef enum logic [13:0] {
      S_IDLE   = 14'b00000000000001,
      S_MAP    = 14'b00000000000010,
      S_MAPW   = 14'b00000000000100,
      S_NODE   = 14'b00000000001000,
      S_NODEW  = 14'b00000000010000,
      S_LEFT   = 14'b00000000100000,
      S_RIGHT  = 14'b00000001000000,
      S_DECIDE = 14'b00000010000000,
      S_SWAP1  = 14'b00000100000000,
      S_SWAP2  = 14'b00001000000000,
      S_PAR    = 14'b00010000000000,
      S_TOP    = 14'b00100000000000,
      S_TOPW   = 14'b01000000000000,
      S_OUT    = 14'b10000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CB-1:0]      count_ff, count_in;
   imh_pkg::op_type    op_ff, op_in;
   logic [KB-1:0]      key_ff, key_in;
   logic [7:0]         id_ff, id_in;
   logic [1:0]         status_ff, status_in;
   logic [SB-1:0]      node_ff, node_in;       // slot being sifted
   logic [SB-1:0]      other_ff, other_in;     // child or parent slot to swap with
   logic [KB-1:0]      nkey_ff, nkey_in;
   logic [SB-1:0]      nent_ff, nent_in;
   logic [KB-1:0]      okey_ff, okey_in;
   logic [SB-1:0]      oent_ff, oent_in;
   logic               up_ff, up_in;           // bubbling up rather than sifting down
   logic               rchk_ff, rchk_in;       // right child pending read
   logic [CB-1:0]      bnode_ff, bnode_in;     // build countdown
   logic               rsp_valid_ff, rsp_valid_in;
   logic [55:0]        rsp_data_ff, rsp_data_in;

   // memories
   logic          kw_en, ew_en, pw_en;
   logic [SB-1:0] kw_addr, ew_addr, pw_addr, k_raddr, p_raddr;
   logic [KB-1:0] kw_data, k_rdata;
   logic [SB-1:0] ew_data, pw_data, e_rdata, p_rdata;

   imh_ram #(.WIDTH(KB), .DEPTH(imh_pkg::CAPACITY)) u_key (
      .clock(clock), .wr_en(kw_en), .wr_addr(kw_addr), .wr_data(kw_data),
      .rd_addr(k_raddr), .rd_data(k_rdata));
   imh_ram #(.WIDTH(SB), .DEPTH(imh_pkg::CAPACITY)) u_ent (
      .clock(clock), .wr_en(ew_en), .wr_addr(ew_addr), .wr_data(ew_data),
      .rd_addr(k_raddr), .rd_data(e_rdata));
   imh_ram #(.WIDTH(SB), .DEPTH(imh_pkg::CAPACITY)) u_pos (
      .clock(clock), .wr_en(pw_en), .wr_addr(pw_addr), .wr_data(pw_data),
      .rd_addr(p_raddr), .rd_data(p_rdata));

   logic          accept;
   logic [CB:0]   lchild, rchild;
   logic [SB-1:0] parent;

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign lchild = (CB+1)'({node_ff, 1'b1});
   assign rchild = {node_ff, 1'b1} + (CB+1)'(1);
   assign parent = SB'((node_ff - SB'(1)) >> 1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in = op_ff;
      key_in = key_ff;
      id_in = id_ff;
      status_in = status_ff;
      node_in = node_ff;
      other_in = other_ff;
      nkey_in = nkey_ff;
      nent_in = nent_ff;
      okey_in = okey_ff;
      oent_in = oent_ff;
      up_in = up_ff;
      rchk_in = rchk_ff;
      bnode_in = bnode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      kw_en = 1'b0; kw_addr = node_ff; kw_data = nkey_ff;
      ew_en = 1'b0; ew_addr = node_ff; ew_data = nent_ff;
      pw_en = 1'b0; pw_addr = nent_ff; pw_data = node_ff;
      k_raddr = '0;
      p_raddr = id_ff[SB-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = imh_pkg::op_type'(req_tdata[1:0]);
               id_in = req_tdata[9:2];
               key_in = req_tdata[41:10];
               status_in = imh_pkg::ST_OK;
               unique case (imh_pkg::op_type'(req_tdata[1:0]))
                  imh_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_TOP;
                  end
                  imh_pkg::OP_LOAD: begin
                     if (count_ff == CB'(imh_pkg::CAPACITY)) begin
                        status_in = imh_pkg::ST_FULL;
                     end else begin
                        kw_en = 1'b1; ew_en = 1'b1; pw_en = 1'b1;
                        kw_addr = count_ff[SB-1:0];
                        kw_data = req_tdata[41:10];
                        ew_addr = count_ff[SB-1:0];
                        ew_data = count_ff[SB-1:0];
                        pw_addr = count_ff[SB-1:0];
                        pw_data = count_ff[SB-1:0];
                        count_in = count_ff + CB'(1);
                     end
                     state_in = S_TOP;
                  end
                  imh_pkg::OP_BUILD: begin
                     bnode_in = count_ff >> 1;
                     state_in = S_NODE;
                     up_in = 1'b0;
                     if ((count_ff >> 1) == '0) begin
                        state_in = S_TOP;
                     end else begin
                        node_in = SB'((count_ff >> 1) - CB'(1));
                        bnode_in = (count_ff >> 1) - CB'(1);
                     end
                  end
                  imh_pkg::OP_UPDATE: begin
                     if ({1'b0, req_tdata[9:2]} >= 9'(count_ff)) begin
                        status_in = imh_pkg::ST_NO_ID;
                        state_in = S_TOP;
                     end else begin
                        state_in = S_MAP;
                     end
                  end
                  default: state_in = S_TOP;
               endcase
            end
         end
         S_MAP: begin
            // position map lookup, then read the slot
            state_in = S_MAPW;
         end
         S_MAPW: begin
            node_in = p_rdata;
            state_in = S_NODE;
         end
         S_NODE: begin
            k_raddr = node_ff;
            state_in = S_NODEW;
         end
         S_NODEW: begin
            if (op_ff == imh_pkg::OP_UPDATE && !rchk_ff) begin
               // first visit on update: write new key, pick direction
               nkey_in = key_ff;
               nent_in = e_rdata;
               up_in = key_ff < k_rdata;
               rchk_in = 1'b1;
               kw_en = 1'b1; kw_addr = node_ff; kw_data = key_ff;
            end else begin
               nkey_in = k_rdata;
               nent_in = e_rdata;
            end
            other_in = node_ff;
            okey_in = (op_ff == imh_pkg::OP_UPDATE && !rchk_ff) ? key_ff : k_rdata;
            if (op_ff == imh_pkg::OP_UPDATE && !rchk_ff ? key_ff < k_rdata : up_ff) begin
               if (node_ff == '0) state_in = S_DECIDE;
               else state_in = S_PAR;
            end else if (lchild < (CB+1)'(count_ff)) begin
               state_in = S_LEFT;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_PAR: begin
            k_raddr = parent;
            other_in = parent;
            state_in = S_RIGHT;
         end
         S_LEFT: begin
            k_raddr = SB'(lchild);
            state_in = S_RIGHT;
         end
         S_RIGHT: begin
            if (up_ff) begin
               if (nkey_ff < k_rdata) begin
                  okey_in = k_rdata; oent_in = e_rdata;
               end else begin
                  // parent not larger: settled here
                  other_in = node_ff;
               end
               state_in = S_DECIDE;
            end else begin
               if (k_rdata < okey_ff) begin
                  okey_in = k_rdata; oent_in = e_rdata; other_in = SB'(lchild);
               end
               if (rchild < (CB+1)'(count_ff) && other_ff == node_ff
                   && !(k_rdata < okey_ff)) begin
                  k_raddr = SB'(rchild);
                  state_in = S_SWAP2;   // reuse as right-read wait
                  rchk_in = 1'b0;
               end else if (rchild < (CB+1)'(count_ff)) begin
                  k_raddr = SB'(rchild);
                  state_in = S_SWAP2;
                  rchk_in = 1'b0;
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_SWAP2: begin
            if (k_rdata < okey_ff) begin
               okey_in = k_rdata; oent_in = e_rdata; other_in = SB'(rchild);
            end
            rchk_in = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (other_ff == node_ff) begin
               // settled
               if (op_ff == imh_pkg::OP_BUILD && bnode_ff != '0) begin
                  bnode_in = bnode_ff - CB'(1);
                  node_in = SB'(bnode_ff - CB'(1));
                  state_in = S_NODE;
               end else begin
                  state_in = S_TOP;
               end
               rchk_in = 1'b0;
            end else begin
               // node slot gets other entry
               kw_en = 1'b1; kw_addr = node_ff; kw_data = okey_ff;
               ew_en = 1'b1; ew_addr = node_ff; ew_data = oent_ff;
               pw_en = 1'b1; pw_addr = oent_ff; pw_data = node_ff;
               state_in = S_SWAP1;
            end
         end
         S_SWAP1: begin
            kw_en = 1'b1; kw_addr = other_ff; kw_data = nkey_ff;
            ew_en = 1'b1; ew_addr = other_ff; ew_data = nent_ff;
            pw_en = 1'b1; pw_addr = nent_ff; pw_data = other_ff;
            node_in = other_ff;
            okey_in = nkey_ff;
            state_in = S_PAR;
            if (!up_ff) begin
               state_in = ((CB+1)'({other_ff, 1'b1}) < (CB+1)'(count_ff)) ? S_LEFT
                                                                          : S_DECIDE;
            end else if (other_ff == '0) begin
               state_in = S_DECIDE;
            end
         end
         S_TOP: begin
            k_raddr = '0;
            state_in = S_TOPW;
         end
         S_TOPW: begin
            state_in = S_OUT;
            okey_in = k_rdata;
            oent_in = e_rdata;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               if (count_ff != '0) begin
                  rsp_data_in[7:0] = 8'(oent_ff);
                  rsp_data_in[39:8] = 32'(okey_ff);
               end
               rsp_data_in[48:40] = 9'(count_ff);
               rsp_data_in[49] = (count_ff == '0);
               rsp_data_in[51:50] = status_ff;
               rchk_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rchk_ff <= 1'b0;
         up_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rchk_ff <= rchk_in;
         up_ff <= up_in;
      end
      op_ff <= op_in;
      key_ff <= key_in;
      id_ff <= id_in;
      status_ff <= status_in;
      node_ff <= node_in;
      other_ff <= other_in;
      nkey_ff <= nkey_in;
      nent_ff <= nent_in;
      okey_ff <= okey_in;
      oent_ff <= oent_in;
      bnode_ff <= bnode_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(imh_pkg::CAPACITY))
      else $error("entry count above capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE)
      else $error("ready outside idle");
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_tdata[1:0] == imh_pkg::OP_CLEAR |=> count_ff == '0)
      else $error("clear left entries");
endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the indexed min-heap: directed table, a full-heap pass, then random ops
module tb_top;
   typedef struct packed {
      logic [1:0]  status;
      logic        heap_empty;
      logic [8:0]  entry_count;
      logic [31:0] top_key;
      logic [7:0]  top_id;
   } heap_report;

   typedef struct {
      imh_pkg::op_type op;
      logic [7:0]      id;
      logic [31:0]     key;
      logic            has_exp;
      heap_report      exp;
   } dir_row;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;

   indexed_min_heap u_top (.*);

   always #2 clock = ~clock;

   // predictor state
   logic [31:0] mdl_key [imh_pkg::CAPACITY];
   logic [7:0]  mdl_entry [imh_pkg::CAPACITY];
   logic [7:0]  mdl_slot [imh_pkg::CAPACITY];
   int          mdl_count;

   heap_report  pending_reports [$];
   int          errors = 0;
   int          cycles = 0;
   int          send_idle_pct = 8;
   int          recv_idle_pct = 59;
   int          hold_off = 0;
   logic        ready_en = 1;

   function automatic void swap_slots(int a, int b);
      logic [31:0] k;
      logic [7:0]  e;
      k = mdl_key[a];
      e = mdl_entry[a];
      mdl_slot[mdl_entry[a]] = b[7:0];
      mdl_slot[mdl_entry[b]] = a[7:0];
      mdl_key[a] = mdl_key[b];
      mdl_entry[a] = mdl_entry[b];
      mdl_key[b] = k;
      mdl_entry[b] = e;
   endfunction

   function automatic void sift_down(int n);
      int l, r, lo;
      while (n < mdl_count) begin
         l = 2 * n + 1;
         r = l + 1;
         lo = n;
         if (l < mdl_count && mdl_key[l] < mdl_key[lo]) lo = l;
         if (r < mdl_count && mdl_key[r] < mdl_key[lo]) lo = r;
         if (lo == n) break;
         swap_slots(n, lo);
         n = lo;
      end
   endfunction

   function automatic void bubble_up(int n);
      int p;
      while (n > 0 && n < mdl_count) begin
         p = (n - 1) / 2;
         if (!(mdl_key[n] < mdl_key[p])) break;
         swap_slots(n, p);
         n = p;
      end
   endfunction

   function automatic heap_report apply_heap_op(imh_pkg::op_type op, logic [7:0] id,
                                                logic [31:0] key);
      heap_report r;
      int s;
      logic [31:0] old;
      r = '0;
      case (op)
         imh_pkg::OP_CLEAR: mdl_count = 0;
         imh_pkg::OP_LOAD: begin
            if (mdl_count >= imh_pkg::CAPACITY) r.status = imh_pkg::ST_FULL;
            else begin
               mdl_key[mdl_count] = key;
               mdl_entry[mdl_count] = mdl_count[7:0];
               mdl_slot[mdl_count] = mdl_count[7:0];
               mdl_count++;
            end
         end
         imh_pkg::OP_BUILD: begin
            for (int i = mdl_count / 2 - 1; i >= 0; i--) sift_down(i);
         end
         default: begin
            if (id >= mdl_count) r.status = imh_pkg::ST_NO_ID;
            else begin
               s = mdl_slot[id];
               old = mdl_key[s];
               mdl_key[s] = key;
               if (key < old) bubble_up(s);
               else sift_down(s);
            end
         end
      endcase
      if (mdl_count == 0) r.heap_empty = 1;
      else begin
         r.top_id = mdl_entry[0];
         r.top_key = mdl_key[0];
      end
      r.entry_count = mdl_count[8:0];
      return r;
   endfunction

   // send one word and log its expected report
   task automatic send_word(imh_pkg::op_type op, logic [7:0] id, logic [31:0] key,
                            logic has_exp, heap_report exp);
      heap_report r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {6'b0, key, id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      r = apply_heap_op(op, id, key);
      if (has_exp && r !== exp) begin
         $display("%0t directed row disagrees with predictor: expected %h, predicted %h",
                  $time, exp, r);
         errors++;
      end
      pending_reports.insert(pending_reports.size(), r);
   endtask

   // receiver side
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            rsp_tready <= 0;
            hold_off <= hold_off - 1;
         end else rsp_tready <= ready_en && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      heap_report got, want;
      cycles <= cycles + 1;
      if (cycles > 20000000) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[51:0];
         if (pending_reports.size() == 0) begin
            $display("%0t report expected none actual %h", $time, got);
            errors++;
         end else begin
            want = pending_reports.pop_front();
            if (got.top_id !== want.top_id)
               $display("%0t top_id expected %h actual %h", $time, want.top_id, got.top_id);
            if (got.top_key !== want.top_key)
               $display("%0t top_key expected %h actual %h", $time, want.top_key, got.top_key);
            if (got.entry_count !== want.entry_count)
               $display("%0t entry_count expected %0d actual %0d", $time,
                        want.entry_count, got.entry_count);
            if (got.heap_empty !== want.heap_empty)
               $display("%0t heap_empty expected %b actual %b", $time,
                        want.heap_empty, got.heap_empty);
            if (got.status !== want.status)
               $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
            if (got !== want) errors++;
         end
      end
   end

   function automatic heap_report rpt(logic [7:0] id, logic [31:0] k, int n, logic e,
                                      imh_pkg::status_type st);
      heap_report r;
      r.top_id = id;
      r.top_key = k;
      r.entry_count = n[8:0];
      r.heap_empty = e;
      r.status = st;
      return r;
   endfunction

   // current predictor top view, used for the heap-full row
   function automatic heap_report mdl_report_bits();
      heap_report r;
      r = '0;
      r.top_id = mdl_entry[0];
      r.top_key = mdl_key[0];
      r.entry_count = mdl_count[8:0];
      return r;
   endfunction

   task automatic random_phase(int n_words);
      int   roll, target;
      imh_pkg::op_type op;
      logic [31:0] k;
      for (int i = 0; i < n_words; i++) begin
         roll = $urandom_range(99);
         // mostly loads and updates, with some builds and rare clears
         if (roll < 3) op = imh_pkg::OP_CLEAR;
         else if (roll < 40) op = imh_pkg::OP_LOAD;
         else if (roll < 47) op = imh_pkg::OP_BUILD;
         else op = imh_pkg::OP_UPDATE;
         if (op == imh_pkg::OP_CLEAR && mdl_count < 4) op = imh_pkg::OP_LOAD;
         case ($urandom_range(3))
            0: k = $urandom;
            1: k = $urandom_range(15);
            2: k = $urandom_range(32'h7fffffff);
            default: k = 32'hffffffff - $urandom_range(3);
         endcase
         target = ($urandom_range(9) == 0) ? $urandom_range(255)
                  : (mdl_count > 0 ? $urandom_range(mdl_count - 1) : 0);
         send_word(op, target[7:0], k, 1'b0, '0);
      end
   endtask

   dir_row dir_rows [$];

   function automatic void add_row(imh_pkg::op_type op, logic [7:0] id, logic [31:0] key,
                                   logic has_exp, heap_report exp);
      dir_row row;
      row.op = op;
      row.id = id;
      row.key = key;
      row.has_exp = has_exp;
      row.exp = exp;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   initial begin
      heap_report none;
      none = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add_row(imh_pkg::OP_BUILD,  8'd0,  32'h0,        1'b1,
              rpt(8'd0, 32'd0, 0, 1'b1, imh_pkg::ST_OK));
      add_row(imh_pkg::OP_UPDATE, 8'd0,  32'h5,        1'b1,
              rpt(8'd0, 32'd0, 0, 1'b1, imh_pkg::ST_NO_ID));
      add_row(imh_pkg::OP_LOAD,   8'hff, 32'hffffffff, 1'b1,
              rpt(8'd0, 32'hffffffff, 1, 1'b0, imh_pkg::ST_OK));
      add_row(imh_pkg::OP_BUILD,  8'd0,  32'h0,        1'b1,
              rpt(8'd0, 32'hffffffff, 1, 1'b0, imh_pkg::ST_OK));
      add_row(imh_pkg::OP_LOAD,   8'd0,  32'h3f800000, 1'b0, none);
      add_row(imh_pkg::OP_LOAD,   8'd0,  32'h0,        1'b0, none);
      add_row(imh_pkg::OP_LOAD,   8'd0,  32'h0,        1'b0, none);
      add_row(imh_pkg::OP_LOAD,   8'd0,  32'h40000000, 1'b0, none);
      add_row(imh_pkg::OP_BUILD,  8'd0,  32'h0,        1'b0, none);
      add_row(imh_pkg::OP_UPDATE, 8'd2,  32'h0,        1'b0, none);
      add_row(imh_pkg::OP_UPDATE, 8'd1,  32'hffffffff, 1'b0, none);
      add_row(imh_pkg::OP_UPDATE, 8'd0,  32'h0,        1'b0, none);
      add_row(imh_pkg::OP_UPDATE, 8'd3,  32'h7f7fffff, 1'b0, none);
      add_row(imh_pkg::OP_UPDATE, 8'd5,  32'h1,        1'b1,
              rpt(8'd0, 32'd0, 5, 1'b0, imh_pkg::ST_NO_ID));
      add_row(imh_pkg::OP_UPDATE, 8'hff, 32'h1,        1'b1,
              rpt(8'd0, 32'd0, 5, 1'b0, imh_pkg::ST_NO_ID));
      add_row(imh_pkg::OP_CLEAR,  8'd0,  32'h0,        1'b1,
              rpt(8'd0, 32'd0, 0, 1'b1, imh_pkg::ST_OK));
      foreach (dir_rows[i])
         send_word(dir_rows[i].op, dir_rows[i].id, dir_rows[i].key,
                   dir_rows[i].has_exp, dir_rows[i].exp);

      // fill to capacity, refuse one more, build and churn the full heap
      for (int i = 0; i < imh_pkg::CAPACITY; i++) begin
         if (i == 40) hold_off = 400;  // long receiver stall while loads are still being offered
         send_word(imh_pkg::OP_LOAD, 8'd0, $urandom, 1'b0, none);
      end
      send_word(imh_pkg::OP_LOAD, 8'd0, 32'h1, 1'b1,
                rpt(8'd0, 32'd0, 0, 1'b0, imh_pkg::ST_FULL) | mdl_report_bits());
      send_word(imh_pkg::OP_BUILD, 8'd0, 32'h0, 1'b0, none);
      for (int i = 0; i < 20; i++)
         send_word(imh_pkg::OP_UPDATE, 8'($urandom_range(255)), $urandom, 1'b0, none);
      send_word(imh_pkg::OP_CLEAR, 8'd0, 32'h0, 1'b0, none);

      random_phase(450);
      send_idle_pct = 59;
      recv_idle_pct = 8;
      random_phase(450);
      send_idle_pct = 0;
      ready_en = 1;
      recv_idle_pct = 0;
      random_phase(550);
      req_tvalid <= 0;

      while (pending_reports.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
